@@ src/fir_impulse_response_convolver_assert.svh @@
// Assertion macros used by the convolver top level.
`ifndef FIR_IMPULSE_RESPONSE_CONVOLVER_ASSERT_SVH
`define FIR_IMPULSE_RESPONSE_CONVOLVER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FIRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FIRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/firc_pkg.sv @@
// Shared types, codes and constants of the FIR convolver.
`default_nettype none
package firc_pkg;

  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned TAP_INDEX_BITS = 12;
  localparam int unsigned TAP_COUNT_BITS = 13;
  localparam int unsigned MAX_TAPS_DEF   = 4096;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned PROD_W         = 2 * SAMPLE_BITS;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, 1'b1, {(SAMPLE_BITS-2){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } firc_state_t;

  typedef struct packed {
    logic                          operation;
    logic [TAP_INDEX_BITS-1:0]     tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
  } firc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_sample;
    logic                          saturated;
  } firc_out_t;

  typedef struct packed {
    logic acc_clr;
    logic rd_vld;
  } firc_mac_ctl_t;

endpackage
`default_nettype wire

@@ src/firc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module firc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/firc_mac.sv @@
// Multiply-accumulate datapath with rounding and saturation of the sum.
`default_nettype none
module firc_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  firc_pkg::firc_mac_ctl_t                ctl,
  input  logic signed [firc_pkg::SAMPLE_BITS-1:0] coef,
  input  logic signed [firc_pkg::SAMPLE_BITS-1:0] samp,
  output logic                                   idle,
  output firc_pkg::firc_out_t                    result
);
  import firc_pkg::*;

  logic                    prod_vld_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]  y_full;
  logic                    sat_hi;
  logic                    sat_lo;

  assign prod_nxt = PROD_W'(coef) * PROD_W'(samp);

  always_comb begin
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // Half an output LSB is added, then the arithmetic shift floors, so ties go up.
  assign rnd_sum = acc_r + ROUND_HALF;
  assign y_full  = rnd_sum >>> (SAMPLE_BITS - 1);
  assign sat_hi  = y_full > ACC_W'(OUT_MAX);
  assign sat_lo  = y_full < ACC_W'(OUT_MIN);

  always_comb begin
    if (sat_hi) begin
      result.filtered_sample = OUT_MAX;
    end else if (sat_lo) begin
      result.filtered_sample = OUT_MIN;
    end else begin
      result.filtered_sample = y_full[SAMPLE_BITS-1:0];
    end
    result.saturated = sat_hi | sat_lo;
  end

  assign idle = !prod_vld_r;

endmodule
`default_nettype wire

@@ src/fir_impulse_response_convolver.sv @@
// Top level of the direct-form FIR convolver: sequencer, stores and output register.
`default_nettype none
`include "fir_impulse_response_convolver_assert.svh"
// After reset the block sweeps the coefficient and history memories to zero, with
// in_ready low; cfg writes are taken throughout. A load beat is written as it is
// taken. A sample beat runs one multiply-accumulate per tap, each reading one
// coefficient and one history word from the two memories through their single read
// ports, then the read and multiply stages drain and the sum is rounded into the
// output register. With a tap count of zero the tap loop is skipped and there is
// nothing to drain. The next beat is taken while a result still waits in that
// register.
module fir_impulse_response_convolver #(
  parameter int unsigned MAX_TAPS = firc_pkg::MAX_TAPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  firc_pkg::firc_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output firc_pkg::firc_out_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [firc_pkg::TAP_COUNT_BITS-1:0]   cfg_wdata
);
  import firc_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W = $clog2(MAX_TAPS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  firc_state_t state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    hist_addr_r, hist_addr_nxt;
  logic [AW-1:0]    coef_addr_r, coef_addr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  firc_out_t        out_data_r, out_data_nxt;
  logic [TAP_COUNT_BITS-1:0] cfg_tap_count_r;

  logic [31:0]      tc_wide;
  logic [CNT_W-1:0] taps_eff;
  logic             accept;
  logic             acc_sample;
  logic             acc_load;
  logic             load_ok;

  logic                   coef_we, hist_we;
  logic [AW-1:0]          coef_waddr, hist_waddr;
  logic [SAMPLE_BITS-1:0] coef_wdata, hist_wdata;
  logic [SAMPLE_BITS-1:0] coef_rdata, hist_rdata;

  firc_mac_ctl_t mac_ctl;
  logic          mac_idle;
  firc_out_t     mac_result;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign acc_sample = accept && (in_data.operation == OP_SAMPLE);
  assign acc_load   = accept && (in_data.operation == OP_LOAD);
  assign load_ok    = 32'(in_data.tap_index) < 32'(MAX_TAPS);

  assign tc_wide  = 32'(cfg_tap_count_r);
  assign taps_eff = (tc_wide > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tc_wide);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc_sample) begin
          state_nxt = (taps_eff == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (remain_r == CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && mac_idle) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    wr_ptr_nxt    = wr_ptr_r;
    hist_addr_nxt = hist_addr_r;
    coef_addr_nxt = coef_addr_r;
    remain_nxt    = remain_r;
    rd_vld_nxt    = (state_r == ST_RUN);
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (acc_sample) begin
          hist_addr_nxt = wr_ptr_r;
          coef_addr_nxt = '0;
          remain_nxt    = taps_eff;
          wr_ptr_nxt    = (wr_ptr_r == LAST_ADDR) ? '0 : wr_ptr_r + 1'b1;
        end
      end
      ST_RUN: begin
        coef_addr_nxt = coef_addr_r + 1'b1;
        hist_addr_nxt = (hist_addr_r == '0) ? LAST_ADDR : hist_addr_r - 1'b1;
        remain_nxt    = remain_r - 1'b1;
      end
      ST_ROUND: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mac_result;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_addr_r      <= '0;
      wr_ptr_r        <= '0;
      remain_r        <= '0;
      rd_vld_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      cfg_tap_count_r <= TAP_COUNT_BITS'(1);
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      remain_r    <= remain_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_tap_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    hist_addr_r <= hist_addr_nxt;
    coef_addr_r <= coef_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // The clearing sweep owns both write ports until it finishes.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = clr_addr_r;
      coef_wdata = '0;
      hist_we    = 1'b1;
      hist_waddr = clr_addr_r;
      hist_wdata = '0;
    end else begin
      coef_we    = acc_load && load_ok;
      coef_waddr = AW'(in_data.tap_index);
      coef_wdata = in_data.value;
      hist_we    = acc_sample;
      hist_waddr = wr_ptr_r;
      hist_wdata = in_data.value;
    end
  end

  firc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_addr_r),
    .rdata (coef_rdata)
  );

  firc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_addr_r),
    .rdata (hist_rdata)
  );

  assign mac_ctl.acc_clr = acc_sample;
  assign mac_ctl.rd_vld  = rd_vld_r;

  firc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef   (coef_rdata),
    .samp   (hist_rdata),
    .idle   (mac_idle),
    .result (mac_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FIRC_ASSERT_NOW(a_idle_pipe_empty, state_r == ST_IDLE, !rd_vld_r && mac_idle,
    "MAC pipeline still busy while the sequencer is idle")
  `FIRC_ASSERT_NOW(a_run_has_taps, state_r == ST_RUN, remain_r != '0,
    "Tap loop running with no taps left")
  `FIRC_ASSERT_NEXT(a_round_loads_out, state_r == ST_ROUND && (!out_valid_r || out_ready),
    out_valid_r && state_r == ST_IDLE, "Rounded result not placed in the output register")
  `FIRC_ASSERT_NEXT(a_ptr_on_sample, acc_sample, wr_ptr_r != $past(wr_ptr_r),
    "History write pointer did not advance after a sample beat")

endmodule
`default_nettype wire

@@ verif/fir_impulse_response_convolver_tb.sv @@
// Self-checking testbench for the FIR convolver: a behavioural prediction of every beat plus checks.
`timescale 1ns / 100ps
module fir_impulse_response_convolver_tb;
  import firc_pkg::*;

  localparam int unsigned MAX_TAPS      = MAX_TAPS_DEF;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
  localparam logic signed [63:0] Y_MAX    = 64'sd8388607;
  localparam logic signed [63:0] Y_MIN    = -64'sd8388608;
  localparam logic signed [63:0] HALF_LSB = 64'sd1 << (SAMPLE_BITS - 2);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  firc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  firc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [TAP_COUNT_BITS-1:0] cfg_wdata = '0;

  fir_impulse_response_convolver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the filter.
  logic signed [SAMPLE_BITS-1:0] ir_taps [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] sample_ring [MAX_TAPS];
  logic [TAP_INDEX_BITS-1:0] ring_ptr = '0;
  logic [TAP_COUNT_BITS-1:0] model_tap_count = 13'd1;
  firc_out_t predicted_filtered [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  firc_out_t oldest;

  function automatic firc_out_t convolve_sample(input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [63:0] acc, c, s, y;
    int unsigned taps, m;
    logic [TAP_INDEX_BITS-1:0] h;
    firc_out_t r;
    sample_ring[ring_ptr] = x;
    taps = (model_tap_count > MAX_TAPS) ? MAX_TAPS : model_tap_count;
    acc = '0;
    for (m = 0; m < taps; m++) begin
      // The ring depth is a power of two, so the pointer subtraction wraps by itself.
      h = ring_ptr - m[TAP_INDEX_BITS-1:0];
      c = ir_taps[m];
      s = sample_ring[h];
      acc = acc + c * s;
    end
    acc = acc + HALF_LSB;
    y = acc >>> (SAMPLE_BITS - 1);
    r.saturated = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      r.saturated = 1'b1;
    end else if (y < Y_MIN) begin
      y = Y_MIN;
      r.saturated = 1'b1;
    end
    r.filtered_sample = y[SAMPLE_BITS-1:0];
    ring_ptr = ring_ptr + 1'b1;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(9))
      0: v = S_MAX;
      1: v = S_MIN;
      2: v = '0;
      3: v = -24'sd1;
      4, 5: v = 24'($urandom_range(8191)) - 24'd4096;
      default: v = SAMPLE_BITS'($urandom());
    endcase
    return v;
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Offers one beat and updates the prediction at the edge where it is taken.
  task automatic send_beat(input logic op, input logic [TAP_INDEX_BITS-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] v);
    firc_in_t beat;
    beat.operation = op;
    beat.tap_index = idx;
    beat.value = v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (beat.operation == OP_LOAD) begin
      ir_taps[beat.tap_index] = beat.value;
    end else begin
      predicted_filtered.push_back(convolve_sample(beat.value));
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
    send_beat(OP_SAMPLE, TAP_INDEX_BITS'($urandom()), v);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (predicted_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The last beat has already been taken, so the input goes quiet before the write.
  task automatic write_tap_count(input logic [TAP_COUNT_BITS-1:0] v);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    model_tap_count = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    // One tap, all coefficients cleared: everything filters to zero.
    send_sample(S_MAX);
    send_sample(S_MIN);
  endtask

  task automatic test_tap_count_zero();
    wait_quiet();
    write_tap_count('0);
    send_beat(OP_LOAD, 12'd0, S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
  endtask

  task automatic test_single_tap_extremes();
    wait_quiet();
    write_tap_count(13'd1);
    // Minus one squared is the only single product that overflows the output.
    send_beat(OP_LOAD, 12'd0, S_MIN);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(-24'sd1);
    send_beat(OP_LOAD, 12'd0, S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    // Products of exactly half an LSB check that ties round upwards.
    send_beat(OP_LOAD, 12'd0, 24'sd2);
    send_sample(24'sd2097152);
    send_sample(-24'sd2097152);
  endtask

  task automatic test_saturation();
    wait_quiet();
    write_tap_count(13'd2);
    send_beat(OP_LOAD, 12'd0, S_MAX);
    send_beat(OP_LOAD, 12'd1, S_MAX);
    send_sample(S_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);
  endtask

  task automatic test_full_depth();
    wait_quiet();
    send_beat(OP_LOAD, 12'd4095, S_MIN);
    write_tap_count(13'd4096);
    send_sample(S_MAX);
    send_sample(pick_value());
    wait_quiet();
    // Counts beyond the store depth are clipped to it.
    write_tap_count(13'd8191);
    send_sample(S_MIN);
  endtask

  task automatic test_backpressure();
    int unsigned k;
    set_idling(0, 0);
    wait_quiet();
    write_tap_count(13'd4);
    hold_asked = hold_asked + 1;
    for (k = 0; k < 8; k++) send_sample(pick_value());
    wait_quiet();
  endtask

  task automatic test_random_traffic();
    int unsigned phase, blk, k, taps, n_loads, n_samples, shift;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_idling(27, 59);
        1: set_idling(59, 27);
        default: set_idling(0, 0);
      endcase
      for (blk = 0; blk < 2; blk++) begin
        if ($urandom_range(99) < 10) begin
          taps = $urandom_range(1) ? MAX_TAPS : $urandom_range(MAX_TAPS, 8191);
          n_samples = 4;
        end else begin
          taps = $urandom_range(0, 24);
          n_samples = 8;
        end
        wait_quiet();
        write_tap_count(taps[TAP_COUNT_BITS-1:0]);
        // A shift of zero leaves full-scale coefficients, so saturation is frequent.
        shift = $urandom_range(0, 6);
        n_loads = (taps < 12) ? taps : 12;
        for (k = 0; k < n_loads; k++) send_beat(OP_LOAD, k[TAP_INDEX_BITS-1:0],
                                                pick_value() >>> shift);
        for (k = 0; k < n_samples; k++) begin
          if ($urandom_range(99) < 15) begin
            send_beat(OP_LOAD, TAP_INDEX_BITS'($urandom_range(1) ? $urandom_range(0, 31)
                                                                  : $urandom()),
                      pick_value() >>> shift);
          end
          send_sample(pick_value());
        end
      end
    end
  endtask

  task automatic test_history_wrap();
    int unsigned k;
    set_idling(0, 0);
    wait_quiet();
    // The write pointer is still near the bottom of the ring, so full-depth runs
    // read back across address zero into the top of the ring.
    for (k = 0; k < 4; k++) begin
      send_beat(OP_LOAD, TAP_INDEX_BITS'($urandom_range(2048, 4095)), pick_value());
    end
    write_tap_count(13'd4096);
    for (k = 0; k < 3; k++) send_sample(pick_value());
    wait_quiet();
  endtask

  // Result side: random back-pressure plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_filtered.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got %0d sat %b", $time,
                 $signed(out_data.filtered_sample), out_data.saturated);
        mismatch_count++;
      end else begin
        oldest = predicted_filtered.pop_front();
        if (out_data.filtered_sample !== oldest.filtered_sample) begin
          $display("%0t: filtered_sample mismatch: expected %0d, got %0d", $time,
                   $signed(oldest.filtered_sample), $signed(out_data.filtered_sample));
          mismatch_count++;
        end
        if (out_data.saturated !== oldest.saturated) begin
          $display("%0t: saturated mismatch: expected %b, got %b", $time,
                   oldest.saturated, out_data.saturated);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < MAX_TAPS; i++) begin
      ir_taps[i] = '0;
      sample_ring[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(27, 59);
    test_reset_state();
    test_tap_count_zero();
    test_single_tap_extremes();
    test_saturation();
    test_full_depth();
    test_random_traffic();
    test_backpressure();
    test_history_wrap();
    wait_quiet();
    if (mismatch_count == 0 && predicted_filtered.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ fir_impulse_response_convolver.f @@
+incdir+src
src/firc_pkg.sv
src/firc_ram.sv
src/firc_mac.sv
src/fir_impulse_response_convolver.sv
verif/fir_impulse_response_convolver_tb.sv
